/* rtl/pvaa_pkg.sv */
// ----------------------------------------------------------------------------
// pvaa_pkg
// Shared types and constants of the polyphonic voice allocator with ADSR
// envelopes: voice record layout, envelope phase codes and register set.
// ----------------------------------------------------------------------------
package pvaa_pkg;

  localparam int VOICES = 8;
  localparam int NOTES  = 128;
  localparam int VIDX_W = $clog2(VOICES);
  localparam int NOTE_W = 7;
  localparam int GAIN_W = 16;
  localparam int HOLD_W = 8;
  localparam int PH_W   = 3;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

  // Envelope phase codes.
  localparam logic [PH_W-1:0] PH_OFF     = 3'd0;
  localparam logic [PH_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PH_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PH_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PH_W-1:0] PH_RELEASE = 3'd4;

  // Input operation codes.
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_BLOCK = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_PEAK    = 3'd3;
  localparam logic [2:0] REG_SUSTAIN = 3'd4;
  localparam logic [2:0] REG_HOLD    = 3'd5;

  // One voice record as held in the voice memory.
  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic [GAIN_W-1:0] gain;
    logic [NOTE_W-1:0] note;
    logic              seen;
    logic [HOLD_W-1:0] hold;
  } voice_t;

  // Envelope and hold settings.
  typedef struct packed {
    logic [7:0]        attack_rate;
    logic [7:0]        decay_rate;
    logic [7:0]        release_rate;
    logic [GAIN_W-1:0] peak_level;
    logic [GAIN_W-1:0] sustain_level;
    logic [HOLD_W-1:0] hold_reload;
  } cfg_t;

endpackage

/* rtl/pvaa_env_step.sv */
// ----------------------------------------------------------------------------
// pvaa_env_step
// Update of one voice record for a block end (hold countdown) or a sample
// tick (one linear ADSR step). Flags when a finished release must check the
// note owner table.
// ----------------------------------------------------------------------------
module pvaa_env_step (
  input  logic            is_tick,
  input  pvaa_pkg::cfg_t  cfg,
  input  pvaa_pkg::voice_t cur,
  output pvaa_pkg::voice_t nxt,
  output logic            owner_chk
);

  logic [pvaa_pkg::GAIN_W:0] att_sum;
  logic [pvaa_pkg::GAIN_W:0] dec_floor;

  assign att_sum   = {1'b0, cur.gain} + {9'd0, cfg.attack_rate};
  assign dec_floor = {1'b0, cfg.sustain_level} + {9'd0, cfg.decay_rate};

  always_comb begin
    nxt       = cur;
    owner_chk = 1'b0;
    if (is_tick) begin
      // One envelope step.
      case (cur.phase)
        pvaa_pkg::PH_ATTACK: begin
          if (att_sum >= {1'b0, cfg.peak_level}) begin
            nxt.gain  = cfg.peak_level;
            nxt.phase = pvaa_pkg::PH_DECAY;
          end else begin
            nxt.gain = att_sum[pvaa_pkg::GAIN_W-1:0];
          end
        end
        pvaa_pkg::PH_DECAY: begin
          if ({1'b0, cur.gain} > dec_floor) begin
            nxt.gain = cur.gain - {8'd0, cfg.decay_rate};
          end else begin
            nxt.gain  = cfg.sustain_level;
            nxt.phase = pvaa_pkg::PH_SUSTAIN;
          end
        end
        pvaa_pkg::PH_SUSTAIN: begin
          nxt.gain = cfg.sustain_level;
        end
        pvaa_pkg::PH_RELEASE: begin
          if (cur.gain > {8'd0, cfg.release_rate}) begin
            nxt.gain = cur.gain - {8'd0, cfg.release_rate};
          end else begin
            nxt.gain  = '0;
            nxt.phase = pvaa_pkg::PH_OFF;
            owner_chk = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      // Hold countdown; unheld voices fall into release.
      if (cur.phase != pvaa_pkg::PH_OFF && cur.phase != pvaa_pkg::PH_RELEASE) begin
        if (!cur.seen && cur.hold != '0) begin
          nxt.hold = cur.hold - 1'b1;
        end else if (cur.hold == '0) begin
          nxt.phase = pvaa_pkg::PH_RELEASE;
        end
      end
      nxt.seen = 1'b0;
    end
  end

endmodule

/* rtl/poly_voice_allocator_adsr_core.sv */
// ----------------------------------------------------------------------------
// poly_voice_allocator_adsr_core
// Note-to-voice allocator with a linear ADSR envelope per voice. Voice
// records and note owners live in synchronous memories, read-modify-write.
//
//   Channel   Ports                               Handshake
//   input     in_op, in_note                      start && !busy
//   result    out_voice, out_level, out_phase_state,
//             out_accepted, out_last              out_valid, one cycle
//   config    psel penable pwrite paddr pwdata    APB write, pready high
//
// A key press keeps busy high through the owner lookup and voice read on a
// retrigger, and while the voice memory is scanned, one voice per cycle,
// plus the owner lookup of a stolen voice. A block end or sample tick keeps
// busy high while every voice is stepped in turn, plus an owner memory
// lookup for each voice whose release ends. Results are registered and
// appear in the cycle after they are formed. Reset is synchronous and needs
// no clearing pass; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module poly_voice_allocator_adsr_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [6:0]  in_note,
  output logic        out_valid,
  output logic [2:0]  out_voice,
  output logic [15:0] out_level,
  output logic [2:0]  out_phase_state,
  output logic        out_accepted,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_K_OWN, S_K_RET, S_K_SCAN, S_K_OLD, S_V_RD, S_V_OWN
  } state_t;

  localparam int VW = pvaa_pkg::VIDX_W;
  localparam int NW = pvaa_pkg::NOTE_W;

  // Configuration registers.
  pvaa_pkg::cfg_t cfg_r;
  logic           cfg_we;
  logic [2:0]     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_rate   <= 8'd16;
      cfg_r.decay_rate    <= 8'd4;
      cfg_r.release_rate  <= 8'd8;
      cfg_r.peak_level    <= 16'd65280;
      cfg_r.sustain_level <= 16'd32768;
      cfg_r.hold_reload   <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_idx)
        pvaa_pkg::REG_ATTACK:  cfg_r.attack_rate   <= pwdata[7:0];
        pvaa_pkg::REG_DECAY:   cfg_r.decay_rate    <= pwdata[7:0];
        pvaa_pkg::REG_RELEASE: cfg_r.release_rate  <= pwdata[7:0];
        pvaa_pkg::REG_PEAK:    cfg_r.peak_level    <= pwdata[15:0];
        pvaa_pkg::REG_SUSTAIN: cfg_r.sustain_level <= pwdata[15:0];
        pvaa_pkg::REG_HOLD:    cfg_r.hold_reload   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      pvaa_pkg::REG_ATTACK:  prdata = {24'd0, cfg_r.attack_rate};
      pvaa_pkg::REG_DECAY:   prdata = {24'd0, cfg_r.decay_rate};
      pvaa_pkg::REG_RELEASE: prdata = {24'd0, cfg_r.release_rate};
      pvaa_pkg::REG_PEAK:    prdata = {16'd0, cfg_r.peak_level};
      pvaa_pkg::REG_SUSTAIN: prdata = {16'd0, cfg_r.sustain_level};
      pvaa_pkg::REG_HOLD:    prdata = {24'd0, cfg_r.hold_reload};
      default:               prdata = '0;
    endcase
  end

  // Voice memory with per-entry valid bits; an unwritten voice reads as zero.
  pvaa_pkg::voice_t vmem [pvaa_pkg::VOICES];
  logic [pvaa_pkg::VOICES-1:0] vvalid_r;
  pvaa_pkg::voice_t vrdata_r;
  logic [VW-1:0]    vraddr;
  logic             vwe;
  logic [VW-1:0]    vwaddr;
  pvaa_pkg::voice_t vwdata;

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    vrdata_r <= vvalid_r[vraddr] ? vmem[vraddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
    end else if (vwe) begin
      vvalid_r[vwaddr] <= 1'b1;
    end
  end

  // Note owner memory; valid bits in flops, cleared at reset.
  logic [VW-1:0]  omem [pvaa_pkg::NOTES];
  logic [pvaa_pkg::NOTES-1:0] ovalid_r;
  logic [VW-1:0]  ordata_r;
  logic [NW-1:0]  oraddr;
  logic           owe;
  logic [NW-1:0]  owaddr;
  logic [VW-1:0]  owdata;
  logic           oclr;
  logic [NW-1:0]  oclr_addr;

  always_ff @(posedge clk) begin
    if (owe) begin
      omem[owaddr] <= owdata;
    end
    ordata_r <= omem[oraddr];
  end

  // Clear first so that a new owner of the same note wins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= '0;
    end else begin
      if (oclr) begin
        ovalid_r[oclr_addr] <= 1'b0;
      end
      if (owe) begin
        ovalid_r[owaddr] <= 1'b1;
      end
    end
  end

  // Operation of the word in progress.
  logic [1:0]       op_r, op_nxt;

  // Envelope step of the voice read this cycle.
  pvaa_pkg::voice_t step_nxt;
  logic             step_owner_chk;

  pvaa_env_step u_step (
    .is_tick   (op_r == pvaa_pkg::OP_TICK),
    .cfg       (cfg_r),
    .cur       (vrdata_r),
    .nxt       (step_nxt),
    .owner_chk (step_owner_chk)
  );

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [NW-1:0]    note_r, note_nxt;
  logic [VW-1:0]    idx_r, idx_nxt;
  pvaa_pkg::voice_t ent_r, ent_nxt;
  logic [15:0]      best_gain_r, best_gain_nxt;
  logic [VW-1:0]    best_idx_r, best_idx_nxt;
  logic [NW-1:0]    best_note_r, best_note_nxt;
  logic             have_rel_r, have_rel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_voice_r, out_voice_nxt;
  logic [15:0]      out_level_r, out_level_nxt;
  logic [2:0]       out_phase_r, out_phase_nxt;
  logic             out_acc_r, out_acc_nxt;
  logic             out_last_r, out_last_nxt;

  pvaa_pkg::voice_t new_voice;
  pvaa_pkg::voice_t ret_voice;
  logic             rel_hit;

  assign busy = (state_r != S_IDLE);

  assign new_voice = '{phase: pvaa_pkg::PH_ATTACK, gain: '0, note: note_r, seen: 1'b1,
                       hold: cfg_r.hold_reload};
  assign rel_hit = (vrdata_r.phase == pvaa_pkg::PH_RELEASE) &&
                   (vrdata_r.gain <= best_gain_r);

  always_comb begin
    ret_voice      = vrdata_r;
    ret_voice.seen = 1'b1;
    ret_voice.hold = cfg_r.hold_reload;
    if (vrdata_r.phase == pvaa_pkg::PH_RELEASE) begin
      ret_voice.phase = pvaa_pkg::PH_ATTACK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    note_nxt      = note_r;
    idx_nxt       = idx_r;
    ent_nxt       = ent_r;
    best_gain_nxt = best_gain_r;
    best_idx_nxt  = best_idx_r;
    best_note_nxt = best_note_r;
    have_rel_nxt  = have_rel_r;
    out_valid_nxt = 1'b0;
    out_voice_nxt = out_voice_r;
    out_level_nxt = out_level_r;
    out_phase_nxt = out_phase_r;
    out_acc_nxt   = out_acc_r;
    out_last_nxt  = out_last_r;
    vraddr        = '0;
    vwe           = 1'b0;
    vwaddr        = idx_r;
    vwdata        = step_nxt;
    oraddr        = note_r;
    owe           = 1'b0;
    owaddr        = note_r;
    owdata        = best_idx_r;
    oclr          = 1'b0;
    oclr_addr     = note_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          note_nxt = in_note;
          idx_nxt  = '0;
          oraddr   = in_note;
          case (in_op)
            pvaa_pkg::OP_KEY:   state_nxt = S_K_OWN;
            pvaa_pkg::OP_BLOCK: state_nxt = S_V_RD;
            pvaa_pkg::OP_TICK:  state_nxt = S_V_RD;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end

      // Owner lookup of the pressed note.
      S_K_OWN: begin
        best_gain_nxt = 16'hFFFF;
        have_rel_nxt  = 1'b0;
        if (ovalid_r[note_r]) begin
          vraddr    = ordata_r;
          idx_nxt   = ordata_r;
          state_nxt = S_K_RET;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_K_SCAN;
        end
      end

      // Retrigger a sounding owner, else drop the stale owner and scan.
      S_K_RET: begin
        if (vrdata_r.phase != pvaa_pkg::PH_OFF) begin
          vwe           = 1'b1;
          vwdata        = ret_voice;
          out_valid_nxt = 1'b1;
          out_voice_nxt = idx_r;
          out_level_nxt = ret_voice.gain;
          out_phase_nxt = ret_voice.phase;
          out_acc_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          oclr      = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_K_SCAN;
        end
      end

      // One voice per cycle: first free voice, else quietest release.
      S_K_SCAN: begin
        if (rel_hit) begin
          best_gain_nxt = vrdata_r.gain;
          best_idx_nxt  = idx_r;
          best_note_nxt = vrdata_r.note;
          have_rel_nxt  = 1'b1;
        end
        if (vrdata_r.phase == pvaa_pkg::PH_OFF) begin
          vwe           = 1'b1;
          vwdata        = new_voice;
          owe           = 1'b1;
          owdata        = idx_r;
          out_valid_nxt = 1'b1;
          out_voice_nxt = idx_r;
          out_level_nxt = '0;
          out_phase_nxt = pvaa_pkg::PH_ATTACK;
          out_acc_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else if (idx_r == pvaa_pkg::LAST_VOICE) begin
          if (rel_hit || have_rel_r) begin
            oraddr    = rel_hit ? vrdata_r.note : best_note_r;
            state_nxt = S_K_OLD;
          end else begin
            out_valid_nxt = 1'b1;
            out_voice_nxt = '0;
            out_level_nxt = '0;
            out_phase_nxt = pvaa_pkg::PH_OFF;
            out_acc_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          vraddr  = idx_r + 1'b1;
        end
      end

      // Steal: release the old note's ownership, then place the new note.
      S_K_OLD: begin
        if (ovalid_r[best_note_r] && ordata_r == best_idx_r) begin
          oclr      = 1'b1;
          oclr_addr = best_note_r;
        end
        vwe           = 1'b1;
        vwaddr        = best_idx_r;
        vwdata        = new_voice;
        owe           = 1'b1;
        owdata        = best_idx_r;
        out_valid_nxt = 1'b1;
        out_voice_nxt = best_idx_r;
        out_level_nxt = '0;
        out_phase_nxt = pvaa_pkg::PH_ATTACK;
        out_acc_nxt   = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end

      // Block end or tick on one voice; finished releases check the owner.
      S_V_RD: begin
        if (step_owner_chk) begin
          ent_nxt   = step_nxt;
          oraddr    = vrdata_r.note;
          state_nxt = S_V_OWN;
        end else begin
          vwe           = 1'b1;
          out_valid_nxt = 1'b1;
          out_voice_nxt = idx_r;
          out_level_nxt = step_nxt.gain;
          out_phase_nxt = step_nxt.phase;
          out_acc_nxt   = 1'b0;
          out_last_nxt  = (idx_r == pvaa_pkg::LAST_VOICE);
          if (idx_r == pvaa_pkg::LAST_VOICE) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            vraddr  = idx_r + 1'b1;
          end
        end
      end

      S_V_OWN: begin
        if (ovalid_r[ent_r.note] && ordata_r == idx_r) begin
          oclr      = 1'b1;
          oclr_addr = ent_r.note;
        end
        vwe           = 1'b1;
        vwdata        = ent_r;
        out_valid_nxt = 1'b1;
        out_voice_nxt = idx_r;
        out_level_nxt = ent_r.gain;
        out_phase_nxt = ent_r.phase;
        out_acc_nxt   = 1'b0;
        out_last_nxt  = (idx_r == pvaa_pkg::LAST_VOICE);
        if (idx_r == pvaa_pkg::LAST_VOICE) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          vraddr    = idx_r + 1'b1;
          state_nxt = S_V_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    note_r      <= note_nxt;
    idx_r       <= idx_nxt;
    ent_r       <= ent_nxt;
    best_gain_r <= best_gain_nxt;
    best_idx_r  <= best_idx_nxt;
    best_note_r <= best_note_nxt;
    have_rel_r  <= have_rel_nxt;
    out_voice_r <= out_voice_nxt;
    out_level_r <= out_level_nxt;
    out_phase_r <= out_phase_nxt;
    out_acc_r   <= out_acc_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_voice       = out_voice_r;
  assign out_level       = out_level_r;
  assign out_phase_state = out_phase_r;
  assign out_accepted    = out_acc_r;
  assign out_last        = out_last_r;

endmodule

/* rtl/pvaa_checker.sv */
// ----------------------------------------------------------------------------
// pvaa_checker
// Port-level checks of the voice allocator: busy framing around accepted
// words and consistency of the result words.
// ----------------------------------------------------------------------------
module pvaa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic [2:0] out_phase_state,
  input logic       out_accepted,
  input logic       out_last
);

  // An accepted word that is not an unused code keeps the block busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == pvaa_pkg::OP_KEY || in_op == pvaa_pkg::OP_BLOCK ||
                       in_op == pvaa_pkg::OP_TICK) |=> busy)
    else $error("busy framing broken");

  // A final result word leaves the block idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("block still busy after final word");

  // Words before the final one come while the block works.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("result word outside an item");

  // A placed key press is a single word with a sounding voice.
  a_acc_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_last && out_phase_state != pvaa_pkg::PH_OFF)
    else $error("bad placement word");

  // Results are not shown back to back after the final word.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("word right after final word");

endmodule

bind poly_voice_allocator_adsr_core pvaa_checker u_pvaa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_phase_state (out_phase_state),
  .out_accepted    (out_accepted),
  .out_last        (out_last)
);
